>>> rtl/core/tkmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkmt_pkg: shared types and constants of the touch key toggle block
// Field widths, register indexes, reset values, event codes and key modes.
// ----------------------------------------------------------------------------
package tkmt_pkg;

  localparam int unsigned KeyW     = 3;
  localparam int unsigned CountW   = 12;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned VelW     = 7;
  localparam int unsigned PixW     = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // quotient bits of the serial divider, one per step
  localparam int unsigned DivSteps = 8;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned ProdW    = CountW + DivSteps;

  // bit offsets inside the output tdata
  localparam int unsigned NoteLsb = 0;
  localparam int unsigned VelLsb  = NoteLsb + NoteW;
  localparam int unsigned PixLsb  = VelLsb + VelW;

  localparam logic [CfgIdxW-1:0] CfgRelease  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFull     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNoteBase = 2'd2;

  localparam logic [CountW-1:0] ReleaseReset  = 12'd3000;
  localparam logic [CountW-1:0] FullReset     = 12'd1500;
  localparam logic [NoteW-1:0]  NoteBaseReset = 7'd60;

  localparam logic [PixW-1:0] PressMax = 8'd255;
  localparam logic [VelW-1:0] VelOff   = 7'h7f;

  localparam logic [KindW-1:0] EvNone = 2'd0;
  localparam logic [KindW-1:0] EvOn   = 2'd1;
  localparam logic [KindW-1:0] EvOff  = 2'd2;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModeOn      = 2'd1,
    ModeLatched = 2'd2,
    ModeOff     = 2'd3
  } key_mode_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPrep = 4'b0010,
    StDiv  = 4'b0100,
    StUpd  = 4'b1000
  } fsm_state_e;

endpackage

>>> rtl/core/touch_key_midi_toggle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_key_midi_toggle: touch sample to midi note toggle
// Maps a touch count to a pressure with a serial divider and runs the
// per-key note on / latch / note off toggle.
// ----------------------------------------------------------------------------
// steps: with the linear map, one setup state, 8 restoring divide steps and one
//   update state; when the count is clamped or the span is zero, setup then update
//   only; the update state waits until the output register is free
// one item at a time: the input is ready only in the idle state
// reset: async active low; levels and note base to defaults, all keys idle,
//   stored velocities and pixels zero, output empty
module touch_key_midi_toggle import tkmt_pkg::*; #(
  parameter int unsigned KEY_COUNT = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // touch_count
  input  logic [KeyW-1:0]     s_axis_tuser,   // key_index
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // note_number, velocity, pixel_level
  output logic [KindW-1:0]    m_axis_tuser    // event_kind
);

  localparam int unsigned KeyIdxW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  fsm_state_e state_q, state_d;

  logic [CountW-1:0] release_q, full_q;
  logic [NoteW-1:0]  note_base_q;

  logic [KeyW-1:0]    key_q, key_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  rem_q, rem_d;
  logic [PixW-1:0]    quo_q, quo_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  key_mode_e       mode_q [KEY_COUNT];
  logic [VelW-1:0] lastv_q [KEY_COUNT];
  logic [PixW-1:0] pix_q [KEY_COUNT];

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [KindW-1:0]    out_kind_q, out_kind_d;

  logic [KeyIdxW-1:0] key_idx;
  logic               key_ok;
  logic [CountW-1:0]  span, diff;
  logic [ProdW-1:0]   prod;
  logic [CountW:0]    trial, trial_sub;
  logic               ge;
  logic               load;
  logic [VelW-1:0]    vel;
  key_mode_e          mode_nx;
  logic [VelW-1:0]    lastv_nx;
  logic [PixW-1:0]    pix_nx;
  logic [KindW-1:0]   kind;
  logic [VelW-1:0]    vel_out;
  logic [NoteW-1:0]   note;

  assign key_ok  = (32'(key_q) < KEY_COUNT);
  assign key_idx = key_ok ? KeyIdxW'(key_q) : '0;
  assign span    = release_q - full_q;
  assign diff    = release_q - count_q;
  // times 255 as times 256 minus one
  assign prod    = {diff, 8'd0} - {8'd0, diff};

  // one restoring divide step
  assign trial     = {rem_q, quo_q[PixW-1]};
  assign trial_sub = trial - {1'b0, span};
  assign ge        = (trial >= {1'b0, span});

  assign load = (state_q == StUpd) && (!out_valid_q || m_axis_tready);
  assign vel  = quo_q[PixW-1:1];
  assign note = note_base_q + NoteW'(key_q);

  assign s_axis_tready = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    count_d = count_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          key_d   = s_axis_tuser;
          count_d = s_axis_tdata[CountW-1:0];
          state_d = StPrep;
        end
      end
      StPrep: begin
        state_d = StUpd;
        if (count_q > release_q) begin
          quo_d = '0;
        end else if (count_q < full_q) begin
          quo_d = PressMax;
        end else if (span == '0) begin
          quo_d = '0;
        end else begin
          rem_d   = prod[ProdW-1:DivSteps];
          quo_d   = prod[DivSteps-1:0];
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d = ge ? trial_sub[CountW-1:0] : trial[CountW-1:0];
        quo_d = {quo_q[PixW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        if (load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // per-key toggle
  always_comb begin
    mode_nx  = mode_q[key_idx];
    lastv_nx = lastv_q[key_idx];
    pix_nx   = pix_q[key_idx];
    kind     = EvNone;
    vel_out  = '0;
    unique case (mode_q[key_idx])
      ModeIdle: begin
        if (vel != '0) begin
          mode_nx  = ModeOn;
          kind     = EvOn;
          vel_out  = vel;
          lastv_nx = vel;
          pix_nx   = {vel, 1'b0};
        end
      end
      ModeOn: begin
        if (vel == '0) begin
          mode_nx = ModeLatched;
        end else if (vel > lastv_q[key_idx]) begin
          kind     = EvOn;
          vel_out  = vel;
          lastv_nx = vel;
          pix_nx   = {vel, 1'b0};
        end
      end
      ModeLatched: begin
        if (vel != '0) begin
          mode_nx = ModeOff;
          kind    = EvOff;
          vel_out = VelOff;
          pix_nx  = '0;
        end
      end
      ModeOff: begin
        if (vel == '0) begin
          mode_nx = ModeIdle;
          pix_nx  = '0;
        end
      end
      default: mode_nx = ModeIdle;
    endcase
    if (!key_ok) begin
      kind    = EvNone;
      vel_out = '0;
      pix_nx  = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_kind_d  = kind;
      out_data_d  = {2'b00, pix_nx, vel_out, note};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      release_q   <= ReleaseReset;
      full_q      <= FullReset;
      note_base_q <= NoteBaseReset;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRelease:  release_q   <= cfg_wdata_i;
          CfgFull:     full_q      <= cfg_wdata_i;
          CfgNoteBase: note_base_q <= cfg_wdata_i[NoteW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        mode_q[k]  <= ModeIdle;
        lastv_q[k] <= '0;
        pix_q[k]   <= '0;
      end
    end else if (load && key_ok) begin
      mode_q[key_idx]  <= mode_nx;
      lastv_q[key_idx] <= lastv_nx;
      pix_q[key_idx]   <= pix_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    count_q    <= count_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

>>> rtl/core/tkmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkmt_checker: port checks of the touch key toggle block
// Watches the stream ports and the event fields of each result transfer.
// ----------------------------------------------------------------------------
module tkmt_checker import tkmt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [KindW-1:0]    m_axis_tuser
);

  logic [VelW-1:0] vel;
  logic [PixW-1:0] pix;

  assign vel = m_axis_tdata[VelLsb +: VelW];
  assign pix = m_axis_tdata[PixLsb +: PixW];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one item in flight: input closes after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after transfer");

  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EvOff) |-> (vel == VelOff) && (pix == '0))
    else $error("note off with wrong velocity or lit pixel");

  a_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EvOn) |-> (vel != '0) && (pix == {vel, 1'b0}))
    else $error("note on velocity and pixel disagree");

  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EvNone) |-> (vel == '0))
    else $error("velocity without event");

endmodule

bind touch_key_midi_toggle tkmt_checker u_tkmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
